// File: rtl/compass_heading_autocal_macros.svh
// ----------------------------------------------------------------------------
// Compass heading assertion macros
// Shared immediate-style wrappers for clocked concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COMPASS_HEADING_AUTOCAL_MACROS_SVH
`define COMPASS_HEADING_AUTOCAL_MACROS_SVH

// Same-cycle implication, gated by reset.
`define CHAC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("compass heading check failed");

// Next-cycle implication, gated by reset.
`define CHAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("compass heading check failed");

`endif

// File: rtl/chac_pkg.sv
// ----------------------------------------------------------------------------
// chac_pkg
// Types, constants and the arctangent table of the compass heading block.
// ----------------------------------------------------------------------------
package chac_pkg;

  localparam int unsigned ANGLE_TABLE_LEN = 24;
  localparam int unsigned PRESCALE_BITS   = 20;
  localparam int unsigned PROD_W          = 36;
  localparam int unsigned VEC_W           = 58;
  localparam int unsigned ACC_W           = 26;

  localparam logic signed [15:0]      BOUND_LOW_RST  = 16'sh7FFF;
  localparam logic signed [15:0]      BOUND_HIGH_RST = 16'sh8000;
  localparam logic signed [ACC_W-1:0] HALF_TURN_Q16  = 26'sd11796480;
  localparam logic signed [ACC_W:0]   ROUND_HALF     = 27'sd256;
  localparam logic signed [ACC_W:0]   HEADING_LIMIT  = 27'sd23040;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] x_low;
    logic signed [15:0] x_high;
    logic signed [15:0] y_low;
    logic signed [15:0] y_high;
    logic        [16:0] span_x;
    logic        [16:0] span_y;
    logic               valid;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_PROD,
    ST_PREP,
    ST_ITER,
    ST_ROUND
  } back_state_e;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ACC_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ACC_W-1:0] r;
    case (idx)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/chac_in_if.sv
// ----------------------------------------------------------------------------
// chac_in_if
// Sample request channel: valid/ready with one x, y, z reading.
// ----------------------------------------------------------------------------
interface chac_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_x;
  logic signed [15:0] sample_y;
  logic signed [15:0] sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

// File: rtl/chac_out_if.sv
// ----------------------------------------------------------------------------
// chac_out_if
// Heading result channel: valid/ready with heading and current bounds.
// ----------------------------------------------------------------------------
interface chac_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading;
  logic               heading_valid;
  logic signed [15:0] bound_x_min;
  logic signed [15:0] bound_x_max;
  logic signed [15:0] bound_y_min;
  logic signed [15:0] bound_y_max;

  modport source (output valid, heading, heading_valid, bound_x_min, bound_x_max,
                  bound_y_min, bound_y_max, input ready);
  modport sink (input valid, heading, heading_valid, bound_x_min, bound_x_max,
                bound_y_min, bound_y_max, output ready);
endinterface

// File: rtl/chac_fifo.sv
// ----------------------------------------------------------------------------
// chac_fifo
// Two-entry queue between the bound tracker and the heading engine.
// ----------------------------------------------------------------------------
module chac_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  chac_pkg::q_entry_t  push_data_i,
  input  logic                pop_i,
  output chac_pkg::q_entry_t  pop_data_o,
  output chac_pkg::fifo_stat_t stat_o
);

  chac_pkg::q_entry_t mem_q [2];
  logic               wptr_q, wptr_d;
  logic               rptr_q, rptr_d;
  logic [1:0]         cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

// File: rtl/chac_front.sv
// ----------------------------------------------------------------------------
// chac_front
// Accepts samples, widens the per-axis bounds and queues the x/y work.
// ----------------------------------------------------------------------------
module chac_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  chac_in_if.sink              in_i,
  input  chac_pkg::fifo_stat_t stat_i,
  output logic                 push_o,
  output chac_pkg::q_entry_t   entry_o
);

  logic signed [15:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;
  logic signed [15:0] x_low_d, x_high_d, y_low_d, y_high_d, z_low_d, z_high_d;
  logic signed [16:0] span_x, span_y;

  assign in_i.ready = !stat_i.full;
  assign push_o     = in_i.valid && !stat_i.full;

  always_comb begin
    x_low_d  = (in_i.sample_x < x_low_q)  ? in_i.sample_x : x_low_q;
    x_high_d = (in_i.sample_x > x_high_q) ? in_i.sample_x : x_high_q;
    y_low_d  = (in_i.sample_y < y_low_q)  ? in_i.sample_y : y_low_q;
    y_high_d = (in_i.sample_y > y_high_q) ? in_i.sample_y : y_high_q;
    z_low_d  = (in_i.sample_z < z_low_q)  ? in_i.sample_z : z_low_q;
    z_high_d = (in_i.sample_z > z_high_q) ? in_i.sample_z : z_high_q;
  end

  // Bounds straddle the sample after the update, so the spans are never negative.
  assign span_x = $signed({x_high_d[15], x_high_d}) - $signed({x_low_d[15], x_low_d});
  assign span_y = $signed({y_high_d[15], y_high_d}) - $signed({y_low_d[15], y_low_d});

  always_comb begin
    entry_o.sample_x = in_i.sample_x;
    entry_o.sample_y = in_i.sample_y;
    entry_o.x_low    = x_low_d;
    entry_o.x_high   = x_high_d;
    entry_o.y_low    = y_low_d;
    entry_o.y_high   = y_high_d;
    entry_o.span_x   = span_x;
    entry_o.span_y   = span_y;
    entry_o.valid    = (span_x != 17'sd0) && (span_y != 17'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= chac_pkg::BOUND_LOW_RST;
      x_high_q <= chac_pkg::BOUND_HIGH_RST;
      y_low_q  <= chac_pkg::BOUND_LOW_RST;
      y_high_q <= chac_pkg::BOUND_HIGH_RST;
      z_low_q  <= chac_pkg::BOUND_LOW_RST;
      z_high_q <= chac_pkg::BOUND_HIGH_RST;
    end else if (push_o) begin
      x_low_q  <= x_low_d;
      x_high_q <= x_high_d;
      y_low_q  <= y_low_d;
      y_high_q <= y_high_d;
      z_low_q  <= z_low_d;
      z_high_q <= z_high_d;
    end
  end

endmodule

// File: rtl/chac_back.sv
// ----------------------------------------------------------------------------
// chac_back
// Hard-iron centering, span cross-scaling and iterative CORDIC atan2.
// ----------------------------------------------------------------------------
module chac_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  chac_pkg::fifo_stat_t stat_i,
  input  chac_pkg::q_entry_t   entry_i,
  output logic                 pop_o,
  chac_out_if.source           out_o
);

  localparam int unsigned NSTEPS = (CORDIC_STEPS > chac_pkg::ANGLE_TABLE_LEN) ?
                                   chac_pkg::ANGLE_TABLE_LEN : CORDIC_STEPS;
  localparam int unsigned CNT_W  = $clog2(NSTEPS);

  chac_pkg::back_state_e state_q, state_d;
  chac_pkg::q_entry_t    entry_q;

  logic signed [17:0]                       xc_q, yc_q;
  logic signed [chac_pkg::PROD_W-1:0]       prod_x_q, prod_y_q;
  logic signed [chac_pkg::VEC_W-1:0]        px_q, py_q;
  logic signed [chac_pkg::ACC_W-1:0]        acc_q;
  logic [CNT_W-1:0]                         cnt_q;
  logic                                     out_valid_q;
  logic signed [15:0]                       heading_q;
  logic                                     hvalid_q;
  logic signed [15:0]                       bxl_q, bxh_q, byl_q, byh_q;

  logic                                     last_step;
  logic                                     zero_vec;
  logic                                     load_out;
  logic signed [16:0]                       sum_x, sum_y, mid_x, mid_y;
  logic signed [chac_pkg::VEC_W-1:0]        ext_x, ext_y, sh_x, sh_y;
  logic signed [chac_pkg::ACC_W-1:0]        angle;
  logic signed [chac_pkg::ACC_W:0]          hsum, hq, hsat;

  assign last_step = (cnt_q == CNT_W'(NSTEPS - 1));
  assign zero_vec  = (prod_x_q == '0) && (prod_y_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chac_pkg::ST_IDLE:   if (!stat_i.empty) state_d = chac_pkg::ST_CENTER;
      chac_pkg::ST_CENTER: state_d = chac_pkg::ST_PROD;
      chac_pkg::ST_PROD:   state_d = chac_pkg::ST_PREP;
      chac_pkg::ST_PREP:   state_d = zero_vec ? chac_pkg::ST_ROUND : chac_pkg::ST_ITER;
      chac_pkg::ST_ITER:   if (last_step) state_d = chac_pkg::ST_ROUND;
      chac_pkg::ST_ROUND:  if (!out_valid_q || out_o.ready) state_d = chac_pkg::ST_IDLE;
      default:             state_d = chac_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      chac_pkg::ST_IDLE:  pop_o    = !stat_i.empty;
      chac_pkg::ST_ROUND: load_out = !out_valid_q || out_o.ready;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chac_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Offset (max+min)/2 truncates toward zero: add one before the shift when negative.
  assign sum_x = $signed({entry_q.x_high[15], entry_q.x_high})
               + $signed({entry_q.x_low[15], entry_q.x_low});
  assign sum_y = $signed({entry_q.y_high[15], entry_q.y_high})
               + $signed({entry_q.y_low[15], entry_q.y_low});
  assign mid_x = (sum_x + $signed({16'd0, sum_x[16]})) >>> 1;
  assign mid_y = (sum_y + $signed({16'd0, sum_y[16]})) >>> 1;

  assign ext_x = chac_pkg::VEC_W'(prod_x_q) <<< chac_pkg::PRESCALE_BITS;
  assign ext_y = chac_pkg::VEC_W'(prod_y_q) <<< chac_pkg::PRESCALE_BITS;

  assign sh_x  = px_q >>> cnt_q;
  assign sh_y  = py_q >>> cnt_q;
  assign angle = chac_pkg::atan_q16(5'(cnt_q));

  assign hsum = (chac_pkg::ACC_W + 1)'(acc_q) + chac_pkg::ROUND_HALF;
  assign hq   = hsum >>> 9;

  always_comb begin
    hsat = hq;
    if (hq > chac_pkg::HEADING_LIMIT) begin
      hsat = chac_pkg::HEADING_LIMIT;
    end else if (hq < -chac_pkg::HEADING_LIMIT) begin
      hsat = -chac_pkg::HEADING_LIMIT;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      chac_pkg::ST_IDLE: begin
        if (pop_o) entry_q <= entry_i;
      end
      chac_pkg::ST_CENTER: begin
        xc_q <= $signed({{2{entry_q.sample_x[15]}}, entry_q.sample_x})
              - $signed({mid_x[16], mid_x});
        yc_q <= $signed({{2{entry_q.sample_y[15]}}, entry_q.sample_y})
              - $signed({mid_y[16], mid_y});
      end
      chac_pkg::ST_PROD: begin
        prod_x_q <= xc_q * $signed({1'b0, entry_q.span_y});
        prod_y_q <= yc_q * $signed({1'b0, entry_q.span_x});
      end
      chac_pkg::ST_PREP: begin
        cnt_q <= '0;
        if (zero_vec) begin
          acc_q <= '0;
        end else if (ext_x < 0) begin
          // Rotate a left-half vector by a half turn first.
          acc_q <= (ext_y >= 0) ? chac_pkg::HALF_TURN_Q16 : -chac_pkg::HALF_TURN_Q16;
          px_q  <= -ext_x;
          py_q  <= -ext_y;
        end else begin
          acc_q <= '0;
          px_q  <= ext_x;
          py_q  <= ext_y;
        end
      end
      chac_pkg::ST_ITER: begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (py_q >= 0) begin
          px_q  <= px_q + sh_y;
          py_q  <= py_q - sh_x;
          acc_q <= acc_q + angle;
        end else begin
          px_q  <= px_q - sh_y;
          py_q  <= py_q + sh_x;
          acc_q <= acc_q - angle;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      heading_q <= entry_q.valid ? hsat[15:0] : 16'sd0;
      hvalid_q  <= entry_q.valid;
      bxl_q     <= entry_q.x_low;
      bxh_q     <= entry_q.x_high;
      byl_q     <= entry_q.y_low;
      byh_q     <= entry_q.y_high;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.heading       = heading_q;
  assign out_o.heading_valid = hvalid_q;
  assign out_o.bound_x_min   = bxl_q;
  assign out_o.bound_x_max   = bxh_q;
  assign out_o.bound_y_min   = byl_q;
  assign out_o.bound_y_max   = byh_q;

endmodule

// File: rtl/compass_heading_autocal.sv
// ----------------------------------------------------------------------------
// compass_heading_autocal
// Self-calibrating compass: min/max hard-iron removal and CORDIC heading.
// ----------------------------------------------------------------------------
// Usage: drive one x, y, z magnetometer sample per request on in_i. Every
// accepted request updates the running per-axis bounds and yields exactly one
// result on out_o: heading in 1/128 degree (-23040..23040), heading_valid
// (both x and y spans nonzero) and the updated x/y bounds.
// Path: an accepted sample passes the queue, then the CENTER, PROD and PREP
// states, the ITER rotations and ROUND before out_o.valid; a sample at the
// hard-iron center skips the rotations.
// Engine: one request at a time, on the single shared shift-add CORDIC stage,
// one micro-rotation per cycle.
// A two-entry queue sits behind the bound tracker, so in_i keeps accepting
// until the queue fills, and the result register frees the engine as soon as
// the previous result is handed over.
// Reset: bounds return to min = 32767, max = -32768; queue and output empty.
// Receiver stall: out_o holds its result; the engine waits, the queue fills,
// and in_i.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`include "compass_heading_autocal_macros.svh"

module compass_heading_autocal #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chac_in_if.sink    in_i,
  chac_out_if.source out_o
);

  logic                 push;
  logic                 pop;
  chac_pkg::q_entry_t   push_entry;
  chac_pkg::q_entry_t   pop_entry;
  chac_pkg::fifo_stat_t fifo_stat;

  chac_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .stat_i  (fifo_stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  chac_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .stat_o      (fifo_stat)
  );

  chac_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (fifo_stat),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  `CHAC_ASSERT_NOW(a_invalid_zero, out_o.valid && !out_o.heading_valid, out_o.heading == 16'sd0)
  `CHAC_ASSERT_NOW(a_heading_range, out_o.valid,
                   (out_o.heading <= chac_pkg::HEADING_LIMIT) &&
                   (out_o.heading >= -chac_pkg::HEADING_LIMIT))
  `CHAC_ASSERT_NOW(a_valid_span, out_o.valid && out_o.heading_valid,
                   (out_o.bound_x_max != out_o.bound_x_min) &&
                   (out_o.bound_y_max != out_o.bound_y_min))
  `CHAC_ASSERT_NEXT(a_pop_not_empty, pop, !$past(fifo_stat.empty))

endmodule
